/* rtl/core/lru_page_frame_table_defines.svh */
// Assertion macros shared by the frame table RTL
`ifndef LRU_PAGE_FRAME_TABLE_DEFINES_SVH
`define LRU_PAGE_FRAME_TABLE_DEFINES_SVH
// Assert that cond implies next-cycle cons
`define LPFT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
// Assert that cond implies cons in the same cycle
`define LPFT_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/lpft_pkg.sv */
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared types and constants for the LRU page frame table.
// ----------------------------------------------------------------------------
package lpft_pkg;
    localparam int FRAMES = 64;
    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);

    localparam logic [2:0] MODE_ADDR   = 3'd0;
    localparam logic [2:0] MODE_PAGE   = 3'd1;
    localparam logic [2:0] MODE_NEW    = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_TOUCH  = 3'd4;

    localparam logic CFG_MEM_SIZE  = 1'b0;
    localparam logic CFG_PAGE_SIZE = 1'b1;

    // Classified command passed from front to back
    typedef struct packed {
        logic [2:0]       mode;
        logic [15:0]      owner;
        logic [31:0]      page;
        logic [CNT_W-1:0] n;
        logic             nop;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE, F_DIVP, F_DIVA, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_SCAN, B_APPLY, B_OUT
    } back_state_t;
endpackage

/* rtl/core/lpft_front.sv */
// ----------------------------------------------------------------------------
// lpft_front
// Accepts transactions, computes frames in use and the page of an address
// with a shared restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module lpft_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           mode,
    input  logic [31:0]          address,
    input  logic [15:0]          owner,
    input  logic [31:0]          page_number,
    input  logic [31:0]          memory_size,
    input  logic [31:0]          page_size,
    output logic                 q_valid,
    input  logic                 q_ready,
    output lpft_pkg::cmd_t       q_cmd
);
    lpft_pkg::front_state_t state_reg, state_next;
    logic [2:0]  mode_reg;
    logic [15:0] owner_reg;
    logic [31:0] pnum_reg;
    logic [31:0] addr_reg;
    logic [31:0] address_hold;
    logic [31:0] num_reg, num_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  bit_reg, bit_next;
    logic [31:0] nq_reg, nq_next;
    logic [32:0] trial;
    logic        zero_div;

    assign zero_div     = (page_size == 32'd0);
    assign trial        = {rem_reg, num_reg[31]} - {1'b0, page_size};
    assign in_ready     = (state_reg == lpft_pkg::F_IDLE);
    assign address_hold = addr_reg;

    // Advance the divider and the sequence
    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        nq_next    = nq_reg;
        case (state_reg)
            lpft_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    num_next   = memory_size;
                    rem_next   = 32'd0;
                    bit_next   = 6'd0;
                    state_next = zero_div ? lpft_pkg::F_PUSH : lpft_pkg::F_DIVP;
                    nq_next    = 32'hFFFF_FFFF;
                end
            end
            lpft_pkg::F_DIVP, lpft_pkg::F_DIVA:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    num_next = {num_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], num_reg[31]};
                    num_next = {num_reg[30:0], 1'b0};
                end
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd31)
                begin
                    bit_next = 6'd0;
                    if (state_reg == lpft_pkg::F_DIVP)
                    begin
                        nq_next = num_next;
                        if (mode_reg == lpft_pkg::MODE_ADDR)
                        begin
                            num_next   = address_hold;
                            rem_next   = 32'd0;
                            state_next = lpft_pkg::F_DIVA;
                        end
                        else
                            state_next = lpft_pkg::F_PUSH;
                    end
                    else
                        state_next = lpft_pkg::F_PUSH;
                end
            end
            lpft_pkg::F_PUSH:
            begin
                if (q_ready)
                    state_next = lpft_pkg::F_IDLE;
            end
            default: state_next = lpft_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lpft_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the transaction and divider data
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        nq_reg  <= nq_next;
        if (state_reg == lpft_pkg::F_IDLE && in_valid)
        begin
            mode_reg  <= mode;
            owner_reg <= owner;
            pnum_reg  <= page_number;
            addr_reg  <= address;
        end
    end

    // Build the classified command
    always_comb
    begin
        q_cmd.mode  = mode_reg;
        q_cmd.owner = owner_reg;
        if (mode_reg == lpft_pkg::MODE_ADDR)
            q_cmd.page = zero_div ? 32'hFFFF_FFFF : num_reg;
        else
            q_cmd.page = pnum_reg;
        if (zero_div || nq_reg >= 32'(lpft_pkg::FRAMES))
            q_cmd.n = lpft_pkg::CNT_W'(lpft_pkg::FRAMES);
        else
            q_cmd.n = nq_reg[lpft_pkg::CNT_W-1:0];
        q_cmd.nop = (q_cmd.n == '0) || (mode_reg > lpft_pkg::MODE_TOUCH);
    end
    assign q_valid = (state_reg == lpft_pkg::F_PUSH);
endmodule

/* rtl/core/lpft_queue.sv */
// ----------------------------------------------------------------------------
// lpft_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module lpft_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpft_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output lpft_pkg::cmd_t out_cmd
);
    lpft_pkg::cmd_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rp_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end
endmodule

/* rtl/core/lpft_back.sv */
// ----------------------------------------------------------------------------
// lpft_back
// Frame store and sequencer: scans frames one per cycle for hits, the first
// free frame and the LRU frame, then applies the update and presents result.
// Frame tags and stamps are read one entry ahead with registered data.
// ----------------------------------------------------------------------------
module lpft_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  lpft_pkg::cmd_t              cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lpft_pkg::IDX_W-1:0]  frame_index,
    output logic                        hit,
    output logic                        evicted,
    output logic [15:0]                 evicted_owner,
    output logic [31:0]                 evicted_page,
    output logic [lpft_pkg::CNT_W-1:0]  frames_affected
);
    localparam int IW = lpft_pkg::IDX_W;
    localparam int CW = lpft_pkg::CNT_W;

    lpft_pkg::back_state_t state_reg, state_next;
    logic [lpft_pkg::FRAMES-1:0] valid_reg;
    logic [15:0] own_mem [lpft_pkg::FRAMES];
    logic [31:0] pg_mem  [lpft_pkg::FRAMES];
    logic [31:0] st_mem  [lpft_pkg::FRAMES];
    logic [lpft_pkg::FRAMES-1:0] st_ok_reg;
    logic [31:0] stamp_reg;
    lpft_pkg::cmd_t cmd_reg;
    logic [CW-1:0] i_reg;
    logic [IW-1:0] ix;
    logic [IW-1:0] rd_ix;
    logic [15:0]   own_q;
    logic [31:0]   pg_q, st_q;
    logic [CW-1:0] cnt_reg;
    logic          hit_reg, free_found_reg;
    logic [IW-1:0] first_hit_reg, free_reg, lru_reg;
    logic [31:0]   lru_st_reg;
    logic [15:0]   lru_own_reg;
    logic [31:0]   lru_pg_reg;
    logic [15:0]   own_rd;
    logic [31:0]   pg_rd, st_rd, stamp_inc;
    logic          v_rd, own_eq, pg_eq;
    logic          is_acc, is_new;
    logic [IW-1:0] tgt;
    logic          tgt_v, ev_c;
    logic [15:0]   tgt_own;
    logic [31:0]   tgt_pg;

    assign ix        = i_reg[IW-1:0];
    assign rd_ix     = (state_reg == lpft_pkg::B_SCAN) ? ix + IW'(1) : '0;
    assign v_rd      = valid_reg[ix];
    assign own_rd    = own_q;
    assign pg_rd     = pg_q;
    assign st_rd     = st_ok_reg[ix] ? st_q : 32'd0;
    assign own_eq    = v_rd && (own_rd == cmd_reg.owner);
    assign pg_eq     = own_eq && (pg_rd == cmd_reg.page);
    assign stamp_inc = (stamp_reg == 32'hFFFF_FFFF) ? stamp_reg : stamp_reg + 32'd1;
    assign is_acc    = (cmd_reg.mode == lpft_pkg::MODE_ADDR) ||
                       (cmd_reg.mode == lpft_pkg::MODE_PAGE);
    assign is_new    = (cmd_reg.mode == lpft_pkg::MODE_NEW);
    assign cmd_ready = (state_reg == lpft_pkg::B_IDLE);

    // Pick the replacement target; the tag matters only for an occupied frame
    always_comb
    begin
        if (free_found_reg && (cmd_reg.mode != lpft_pkg::MODE_PAGE))
            tgt = free_reg;
        else
            tgt = lru_reg;
        tgt_v   = valid_reg[tgt];
        tgt_own = lru_own_reg;
        tgt_pg  = lru_pg_reg;
        ev_c    = tgt_v;
    end

    // Sequence next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpft_pkg::B_IDLE:
                if (cmd_valid)
                    state_next = cmd.nop ? lpft_pkg::B_OUT : lpft_pkg::B_SCAN;
            lpft_pkg::B_SCAN:
                if (i_reg == cmd_reg.n - CW'(1))
                    state_next = lpft_pkg::B_APPLY;
            lpft_pkg::B_APPLY:
                state_next = lpft_pkg::B_OUT;
            lpft_pkg::B_OUT:
                if (out_ready)
                    state_next = lpft_pkg::B_IDLE;
            default: state_next = lpft_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpft_pkg::B_IDLE;
            valid_reg <= '0;
            st_ok_reg <= '0;
            stamp_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lpft_pkg::B_SCAN)
            begin
                // Update per-frame effects in index order
                if ((is_acc && pg_eq) || (cmd_reg.mode == lpft_pkg::MODE_TOUCH && own_eq))
                begin
                    stamp_reg     <= stamp_inc;
                    st_ok_reg[ix] <= 1'b1;
                end
                if (cmd_reg.mode == lpft_pkg::MODE_REMOVE && own_eq)
                begin
                    valid_reg[ix] <= 1'b0;
                    st_ok_reg[ix] <= 1'b0;
                end
            end
            if (state_reg == lpft_pkg::B_APPLY && (is_new || (is_acc && !hit_reg)))
            begin
                valid_reg[tgt] <= 1'b1;
                st_ok_reg[tgt] <= 1'b1;
                stamp_reg      <= stamp_inc;
            end
        end
    end

    // Frame store and scan bookkeeping
    always_ff @(posedge clk)
    begin
        // Read the next frame to be scanned
        own_q <= own_mem[rd_ix];
        pg_q  <= pg_mem[rd_ix];
        st_q  <= st_mem[rd_ix];
        case (state_reg)
            lpft_pkg::B_IDLE:
            begin
                cmd_reg        <= cmd;
                i_reg          <= '0;
                cnt_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                first_hit_reg  <= '0;
                free_reg       <= '0;
                lru_reg        <= '0;
                lru_st_reg     <= 32'hFFFF_FFFF;
                lru_own_reg    <= 16'd0;
                lru_pg_reg     <= 32'd0;
                frame_index     <= '0;
                hit             <= 1'b0;
                evicted         <= 1'b0;
                evicted_owner   <= 16'd0;
                evicted_page    <= 32'd0;
                frames_affected <= '0;
            end
            lpft_pkg::B_SCAN:
            begin
                i_reg <= i_reg + CW'(1);
                if ((is_acc && pg_eq) || (cmd_reg.mode == lpft_pkg::MODE_TOUCH && own_eq))
                begin
                    st_mem[ix] <= stamp_inc;
                    cnt_reg    <= cnt_reg + CW'(1);
                    if (!hit_reg)
                        first_hit_reg <= ix;
                    hit_reg <= 1'b1;
                end
                if (cmd_reg.mode == lpft_pkg::MODE_REMOVE && own_eq)
                    cnt_reg <= cnt_reg + CW'(1);
                if (!v_rd && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_reg       <= ix;
                end
                // Strict less keeps lowest index; first frame always taken
                if (i_reg == '0 || st_rd < lru_st_reg)
                begin
                    lru_reg     <= ix;
                    lru_st_reg  <= st_rd;
                    lru_own_reg <= own_rd;
                    lru_pg_reg  <= pg_rd;
                end
            end
            lpft_pkg::B_APPLY:
            begin
                frames_affected <= cnt_reg;
                if (is_acc && hit_reg)
                begin
                    frame_index <= first_hit_reg;
                    hit         <= 1'b1;
                end
                else if (is_acc || is_new)
                begin
                    frame_index     <= tgt;
                    frames_affected <= CW'(1);
                    evicted         <= ev_c;
                    evicted_owner   <= ev_c ? tgt_own : 16'd0;
                    evicted_page    <= ev_c ? tgt_pg : 32'd0;
                    own_mem[tgt]    <= cmd_reg.owner;
                    st_mem[tgt]     <= stamp_inc;
                    if (is_new)
                        pg_mem[tgt] <= tgt_v ? cmd_reg.page : 32'd0;
                    else
                        pg_mem[tgt] <= cmd_reg.page;
                end
                else
                begin
                    frame_index <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = (state_reg == lpft_pkg::B_OUT);
endmodule

/* rtl/core/lru_page_frame_table.sv */
// ----------------------------------------------------------------------------
// lru_page_frame_table
// Fully associative LRU page frame table, top level.
// ----------------------------------------------------------------------------
// Usage: a transaction on the input channel (mode, address, owner,
// page_number) gives exactly one result transaction on the output channel.
// Registers memory_size (index 0) and page_size (index 1) must be written
// over the cfg channel only while the block is idle; the block itself does
// not enforce this. cfg_ready is always high. The front divides memory_size
// by page_size and, for access by address, address by page_size; a zero
// page size skips both. The back scans the n frames in use one per cycle,
// then applies and presents; an unused mode or an empty table skips the scan
// and the apply. The front takes a new transaction only after it has pushed
// the last one into the queue, and the back takes the next command only after
// its result is accepted; the queue lets the front divide the next one while
// the back scans.
// Reset clears every frame to free, all stamps and the stamp counter; no
// clearing pass is needed. A stalled receiver holds the result and the back,
// and the front then stalls once the queue is full.
// ----------------------------------------------------------------------------
`include "lru_page_frame_table_defines.svh"

module lru_page_frame_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] address,
    input  logic [15:0] owner,
    input  logic [31:0] page_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  frame_index,
    output logic        hit,
    output logic        evicted,
    output logic [15:0] evicted_owner,
    output logic [31:0] evicted_page,
    output logic [6:0]  frames_affected
);
    logic [31:0]    mem_size_reg, page_size_reg;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    lpft_pkg::cmd_t fq_cmd, qb_cmd;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg  <= 32'd65536;
            page_size_reg <= 32'd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lpft_pkg::CFG_MEM_SIZE:  mem_size_reg  <= cfg_data;
                lpft_pkg::CFG_PAGE_SIZE: page_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lpft_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .address(address), .owner(owner), .page_number(page_number),
        .memory_size(mem_size_reg), .page_size(page_size_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
    );

    lpft_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_cmd(fq_cmd),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_cmd(qb_cmd)
    );

    lpft_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .frame_index(frame_index), .hit(hit), .evicted(evicted),
        .evicted_owner(evicted_owner), .evicted_page(evicted_page),
        .frames_affected(frames_affected)
    );

    `LPFT_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted)
    `LPFT_ASSERT_NOW(a_evict_one, out_valid && evicted, frames_affected == 7'd1)
    `LPFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_index))
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the LRU page frame table. A behavioral frame
// table predicts every result; bursty stimulus and a stalling receiver
// exercise hits, fills, LRU evictions, process removal and touch, across
// several memory and page size settings including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
    typedef struct {
        logic [2:0]  mode;
        logic [31:0] address;
        logic [15:0] owner;
        logic [31:0] page_number;
    } op_t;

    typedef struct {
        logic [5:0]  frame_index;
        logic        hit;
        logic        evicted;
        logic [15:0] evicted_owner;
        logic [31:0] evicted_page;
        logic [6:0]  frames_affected;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  mode;
    logic [31:0] address;
    logic [15:0] owner;
    logic [31:0] page_number;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  frame_index;
    logic        hit;
    logic        evicted;
    logic [15:0] evicted_owner;
    logic [31:0] evicted_page;
    logic [6:0]  frames_affected;

    // Predictor state
    logic        pf_valid [lpft_pkg::FRAMES];
    logic [15:0] pf_owner [lpft_pkg::FRAMES];
    logic [31:0] pf_page [lpft_pkg::FRAMES];
    logic [31:0] pf_stamp [lpft_pkg::FRAMES];
    logic [31:0] pf_clock;
    logic [31:0] pf_mem_size;
    logic [31:0] pf_page_size;

    op_t  pending_ops[$];
    res_t expected_results[$];
    int   error_count;
    bit   hold_on;
    int   hold_cycles;
    int   burst_left;
    int   gap_left;
    int   stall_phase;

    lru_page_frame_table dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("lru_page_frame_table test failed");
        $finish;
    end

    function automatic int frames_live();
        logic [31:0] q;
        if (pf_page_size == 0)
            return lpft_pkg::FRAMES;
        q = pf_mem_size / pf_page_size;
        return (q > lpft_pkg::FRAMES) ? lpft_pkg::FRAMES : int'(q);
    endfunction

    function automatic void bump_stamp(int i);
        if (pf_clock != 32'hFFFF_FFFF)
            pf_clock = pf_clock + 32'd1;
        pf_stamp[i] = pf_clock;
    endfunction

    function automatic int oldest_frame(int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++)
            if (pf_stamp[i] < pf_stamp[best])
                best = i;
        return best;
    endfunction

    function automatic int first_free(int n);
        for (int i = 0; i < n; i++)
            if (!pf_valid[i])
                return i;
        return -1;
    endfunction

    // Apply one operation to the frame table model and return its result
    function automatic res_t table_update(op_t op);
        res_t r;
        int n;
        int idx;
        logic [31:0] pg;
        r = '{default: '0};
        n = frames_live();
        if (n == 0 || op.mode > lpft_pkg::MODE_TOUCH)
            return r;
        case (op.mode)
            lpft_pkg::MODE_ADDR, lpft_pkg::MODE_PAGE:
            begin
                if (op.mode == lpft_pkg::MODE_PAGE)
                    pg = op.page_number;
                else if (pf_page_size == 0)
                    pg = 32'hFFFF_FFFF;
                else
                    pg = op.address / pf_page_size;
                for (int i = 0; i < n; i++)
                    if (pf_valid[i] && pf_owner[i] == op.owner && pf_page[i] == pg)
                    begin
                        if (!r.hit)
                            r.frame_index = 6'(i);
                        r.hit = 1'b1;
                        r.frames_affected++;
                        bump_stamp(i);
                    end
                if (!r.hit)
                begin
                    idx = (op.mode == lpft_pkg::MODE_ADDR) ? first_free(n) : -1;
                    if (idx < 0)
                        idx = oldest_frame(n);
                    if (pf_valid[idx])
                    begin
                        r.evicted = 1'b1;
                        r.evicted_owner = pf_owner[idx];
                        r.evicted_page = pf_page[idx];
                    end
                    pf_valid[idx] = 1'b1;
                    pf_owner[idx] = op.owner;
                    pf_page[idx] = pg;
                    bump_stamp(idx);
                    r.frame_index = 6'(idx);
                    r.frames_affected = 7'd1;
                end
            end
            lpft_pkg::MODE_NEW:
            begin
                idx = first_free(n);
                if (idx >= 0)
                    pf_page[idx] = '0;
                else
                begin
                    idx = oldest_frame(n);
                    r.evicted = 1'b1;
                    r.evicted_owner = pf_owner[idx];
                    r.evicted_page = pf_page[idx];
                    pf_page[idx] = op.page_number;
                end
                pf_valid[idx] = 1'b1;
                pf_owner[idx] = op.owner;
                bump_stamp(idx);
                r.frame_index = 6'(idx);
                r.frames_affected = 7'd1;
            end
            lpft_pkg::MODE_REMOVE:
                for (int i = 0; i < n; i++)
                    if (pf_valid[i] && pf_owner[i] == op.owner)
                    begin
                        pf_valid[i] = 1'b0;
                        pf_stamp[i] = '0;
                        r.frames_affected++;
                    end
            default:
                for (int i = 0; i < n; i++)
                    if (pf_valid[i] && pf_owner[i] == op.owner)
                    begin
                        bump_stamp(i);
                        r.frames_affected++;
                    end
        endcase
        return r;
    endfunction

    // Drive the input channel in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= '0;
            address <= '0;
            owner <= '0;
            page_number <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_results = {expected_results, table_update(pending_ops.pop_front())};
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                in_valid <= 1'b1;
                mode <= pending_ops[0].mode;
                address <= pending_ops[0].address;
                owner <= pending_ops[0].owner;
                page_number <= pending_ops[0].page_number;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the receiver on its own pattern, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase = 0;
            hold_cycles = 0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 400;
            if (hold_on)
            begin
                hold_cycles++;
                out_ready <= (hold_cycles > 3000);
            end
            else if (stall_phase < 150)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, frame %0d", $time, frame_index);
                error_count++;
            end
            else
            begin
                res_t e;
                e = expected_results.pop_front();
                if (e.frame_index !== frame_index)
                begin
                    $display("%0t: frame_index expected %0d actual %0d",
                             $time, e.frame_index, frame_index);
                    error_count++;
                end
                if (e.hit !== hit)
                begin
                    $display("%0t: hit expected %0d actual %0d", $time, e.hit, hit);
                    error_count++;
                end
                if (e.evicted !== evicted)
                begin
                    $display("%0t: evicted expected %0d actual %0d",
                             $time, e.evicted, evicted);
                    error_count++;
                end
                if (e.evicted_owner !== evicted_owner)
                begin
                    $display("%0t: evicted_owner expected %h actual %h",
                             $time, e.evicted_owner, evicted_owner);
                    error_count++;
                end
                if (e.evicted_page !== evicted_page)
                begin
                    $display("%0t: evicted_page expected %h actual %h",
                             $time, e.evicted_page, evicted_page);
                    error_count++;
                end
                if (e.frames_affected !== frames_affected)
                begin
                    $display("%0t: frames_affected expected %0d actual %0d",
                             $time, e.frames_affected, frames_affected);
                    error_count++;
                end
            end
        end
    end

    task automatic add_op(logic [2:0] m, logic [31:0] a, logic [15:0] o, logic [31:0] p);
        op_t op;
        op.mode = m;
        op.address = a;
        op.owner = o;
        op.page_number = p;
        pending_ops = {pending_ops, op};
    endtask

    // Wait until every queued and expected transaction has drained
    task automatic drain();
        while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == lpft_pkg::CFG_MEM_SIZE)
            pf_mem_size = val;
        else
            pf_page_size = val;
        @(posedge clk);
    endtask

    // Random operation on a small pool of owners and pages so hits recur
    task automatic add_random_op();
        logic [2:0]  m;
        logic [15:0] o;
        logic [31:0] p;
        logic [31:0] a;
        int r;
        r = $urandom_range(0, 99);
        m = (r < 40) ? lpft_pkg::MODE_ADDR : (r < 65) ? lpft_pkg::MODE_PAGE :
            (r < 78) ? lpft_pkg::MODE_NEW : (r < 86) ? lpft_pkg::MODE_REMOVE :
            (r < 96) ? lpft_pkg::MODE_TOUCH : 3'($urandom_range(5, 7));
        o = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        p = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 11));
        a = ($urandom_range(0, 9) == 0) ? $urandom
            : p * pf_page_size + $urandom_range(0, 3);
        add_op(m, a, o, p);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            add_random_op();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        hold_on = 1'b0;
        for (int i = 0; i < lpft_pkg::FRAMES; i++)
        begin
            pf_valid[i] = 1'b0;
            pf_owner[i] = '0;
            pf_page[i] = '0;
            pf_stamp[i] = '0;
        end
        pf_clock = '0;
        pf_mem_size = 32'd65536;
        pf_page_size = 32'd1024;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every mode, field extremes, unused modes
        add_op(lpft_pkg::MODE_ADDR, 32'h0, 16'h0, 32'h0);
        add_op(lpft_pkg::MODE_ADDR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_op(lpft_pkg::MODE_ADDR, 32'h3FF, 16'h0, 32'h0);
        add_op(lpft_pkg::MODE_PAGE, 32'h0, 16'hFFFF, 32'h3F_FFFF);
        add_op(lpft_pkg::MODE_PAGE, 32'hFFFF_FFFF, 16'h1, 32'hFFFF_FFFF);
        add_op(lpft_pkg::MODE_NEW, 32'h0, 16'h7, 32'h1234_5678);
        add_op(lpft_pkg::MODE_TOUCH, 32'h0, 16'hFFFF, 32'h0);
        add_op(lpft_pkg::MODE_REMOVE, 32'h0, 16'h0, 32'h0);
        add_op(3'd5, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555);
        add_op(3'd6, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA);
        add_op(3'd7, 32'h0, 16'h0, 32'h0);
        add_op(lpft_pkg::MODE_REMOVE, 32'h0, 16'hFFFF, 32'h0);
        add_op(lpft_pkg::MODE_TOUCH, 32'h0, 16'h7, 32'h0);
        drain();

        // Tiny table: forced evictions, mode 0 choosing a free frame
        write_reg(lpft_pkg::CFG_MEM_SIZE, 32'd4);
        write_reg(lpft_pkg::CFG_PAGE_SIZE, 32'd1);
        for (int i = 0; i < 6; i++)
            add_op(lpft_pkg::MODE_NEW, 32'h0, 16'(i), 32'(i + 100));
        add_op(lpft_pkg::MODE_REMOVE, 32'h0, 16'd4, 32'h0);
        add_op(lpft_pkg::MODE_PAGE, 32'h0, 16'd9, 32'd9);
        add_op(lpft_pkg::MODE_ADDR, 32'd3, 16'd9, 32'h0);
        drain();

        // Memory smaller than one page: no frames in use
        write_reg(lpft_pkg::CFG_MEM_SIZE, 32'd1);
        write_reg(lpft_pkg::CFG_PAGE_SIZE, 32'hFFFF_FFFF);
        random_phase(20);

        // Zero page size: all frames, saturated page numbers
        write_reg(lpft_pkg::CFG_MEM_SIZE, 32'hFFFF_FFFF);
        write_reg(lpft_pkg::CFG_PAGE_SIZE, 32'd0);
        random_phase(150);

        // Long receiver hold-off while the sender keeps offering
        write_reg(lpft_pkg::CFG_MEM_SIZE, 32'd8192);
        write_reg(lpft_pkg::CFG_PAGE_SIZE, 32'd1024);
        hold_on = 1'b1;
        for (int i = 0; i < 60; i++)
            add_random_op();
        while (hold_cycles <= 3000)
            @(posedge clk);
        hold_on = 1'b0;
        drain();

        // Several random settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(lpft_pkg::CFG_MEM_SIZE, 32'($urandom_range(1, 20)) * 32'd256);
            write_reg(lpft_pkg::CFG_PAGE_SIZE, 32'd256 << $urandom_range(0, 2));
            random_phase(250);
        end
        write_reg(lpft_pkg::CFG_MEM_SIZE, 32'd65536);
        write_reg(lpft_pkg::CFG_PAGE_SIZE, 32'd1024);
        random_phase(250);

        drain();
        if (error_count == 0)
            $display("lru_page_frame_table test passed");
        else
            $display("lru_page_frame_table test failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lpft_pkg.sv
rtl/core/lpft_front.sv
rtl/core/lpft_queue.sv
rtl/core/lpft_back.sv
rtl/core/lru_page_frame_table.sv
tb/sv/tb_top.sv
